// ----- rtl/core/minv_pkg.sv -----
// Shared types and constants for the 3x3 fixed-point matrix inverter.
package minv_pkg;

  localparam int ElemW   = 16;
  localparam int FracW   = 8;
  localparam int OutFrac = 16;
  localparam int MinorW  = 2 * ElemW + 1;           // 33
  localparam int DetW    = 49;
  localparam int QuoW    = 32;
  localparam int ShiftW  = FracW + OutFrac;         // 24 fraction steps
  localparam int MagW    = MinorW + ShiftW;         // dividend magnitude width
  localparam int PosW    = 4;
  localparam int NumPos  = 9;
  localparam int QDepth  = 2;

  typedef logic signed [ElemW-1:0] elem_t;

  // Request passed from the load front end to the compute back end.
  typedef struct packed {
    elem_t [NumPos-1:0] mat;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MINOR, S_DET, S_DIV, S_OUT
  } back_state_e;

endpackage

// ----- rtl/core/minv_if.sv -----
// Valid/ready channel interfaces for input and result items.
interface minv_in_if;
  logic                          valid;
  logic                          ready;
  logic [minv_pkg::PosW-1:0]     position;
  logic signed [minv_pkg::ElemW-1:0] element;
  logic                          start_req;
  modport source (output valid, position, element, start_req, input ready);
  modport sink   (input valid, position, element, start_req, output ready);
endinterface

interface minv_out_if;
  logic                              valid;
  logic                              ready;
  logic [minv_pkg::PosW-1:0]         out_position;
  logic signed [minv_pkg::QuoW-1:0]  inverse_value;
  logic signed [minv_pkg::DetW-1:0]  determinant;
  logic                              singular;
  logic                              clipped;
  logic                              last_entry;
  modport source (output valid, out_position, inverse_value, determinant, singular,
                  clipped, last_entry, input ready);
  modport sink   (input valid, out_position, inverse_value, determinant, singular,
                  clipped, last_entry, output ready);
endinterface

// ----- rtl/core/minv_front.sv -----
// Load front end: element store and snapshot into the job queue on a start request.
module minv_front (
  input  logic clk_i,
  input  logic rst_ni,
  minv_in_if.sink in_ch,
  output logic job_valid_o,
  output minv_pkg::job_t job_o,
  input  logic job_ready_i
);
  minv_pkg::elem_t [minv_pkg::NumPos-1:0] mat_q;
  minv_pkg::job_t [minv_pkg::QDepth-1:0] q_mem_q;
  logic q_wp_q, q_rp_q;
  logic [1:0] q_cnt_q;
  logic acc, push, pop;
  minv_pkg::job_t snap;

  assign in_ch.ready = (q_cnt_q != 2'd2);
  assign acc  = in_ch.valid && in_ch.ready;
  assign push = acc && in_ch.start_req;
  assign pop  = job_valid_o && job_ready_i;
  assign job_valid_o = (q_cnt_q != 2'd0);
  assign job_o = q_mem_q[q_rp_q];

  // snapshot includes the element written by this same request
  always_comb begin
    snap.mat = mat_q;
    if (in_ch.position < minv_pkg::PosW'(minv_pkg::NumPos))
      snap.mat[in_ch.position] = in_ch.element;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q   <= '0;
      q_wp_q  <= 1'b0;
      q_rp_q  <= 1'b0;
      q_cnt_q <= 2'd0;
    end else begin
      if (acc) mat_q <= snap.mat;
      if (push) q_wp_q <= ~q_wp_q;
      if (pop)  q_rp_q <= ~q_rp_q;
      q_cnt_q <= q_cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[q_wp_q] <= snap;
  end
endmodule

// ----- rtl/core/minv_div.sv -----
// Restoring serial divider: one quotient bit per cycle with early saturation.
module minv_div (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic signed [minv_pkg::MinorW-1:0] num_i,
  input  logic signed [minv_pkg::DetW-1:0]   den_i,
  output logic done_o,
  output logic signed [minv_pkg::QuoW-1:0] quo_o,
  output logic clip_o
);
  localparam int CntW = $clog2(minv_pkg::MagW + 1);
  localparam int NW = minv_pkg::MagW;

  logic busy_q, neg_q, clip_q;
  logic [CntW-1:0] cnt_q;
  logic [NW-1:0] n_q;          // remaining dividend bits, shifted out at top
  logic [minv_pkg::DetW:0] r_q, d_q;
  logic [32:0] q_q;
  logic [32:0] limit;
  logic [minv_pkg::DetW:0] r_sh;
  logic ge;
  logic [32:0] q_nx;

  assign limit = neg_q ? 33'h1_0000_0000 >> 1 : 33'h0_7FFF_FFFF;
  assign r_sh  = {r_q[minv_pkg::DetW-1:0], n_q[NW-1]};
  assign ge    = r_sh >= d_q;
  assign q_nx  = {q_q[31:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (cnt_q == CntW'(1) || q_nx > limit) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // long division of |num| * 2^24 by |den|
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= num_i[minv_pkg::MinorW-1] ^ den_i[minv_pkg::DetW-1];
      n_q    <= {(num_i[minv_pkg::MinorW-1] ? -num_i : num_i), minv_pkg::ShiftW'(0)};
      d_q    <= {1'b0, (den_i[minv_pkg::DetW-1] ? -den_i : den_i)};
      r_q    <= '0;
      q_q    <= '0;
      cnt_q  <= CntW'(NW);
      clip_q <= 1'b0;
    end else if (busy_q) begin
      n_q   <= {n_q[NW-2:0], 1'b0};
      r_q   <= ge ? r_sh - d_q : r_sh;
      q_q   <= q_nx;
      cnt_q <= cnt_q - CntW'(1);
      if (q_nx > limit) clip_q <= 1'b1;
    end
  end

  logic [32:0] q_fin;
  logic clip_fin;
  assign clip_fin = clip_q;
  assign q_fin = clip_q ? limit : q_q;
  assign quo_o  = neg_q ? 32'(-q_fin) : 32'(q_fin);
  assign clip_o = clip_fin;
endmodule

// ----- rtl/core/minv_back.sv -----
// Compute back end: minors, determinant, nine serial divisions if nonsingular, output register.
module minv_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  minv_pkg::job_t job_i,
  output logic job_ready_o,
  minv_out_if.source out_ch
);
  minv_pkg::back_state_e st_q, st_d;
  minv_pkg::elem_t [minv_pkg::NumPos-1:0] m_q;
  logic signed [minv_pkg::MinorW-1:0] cof_q [minv_pkg::NumPos];
  logic signed [minv_pkg::DetW-1:0] det_q, prod_q;
  logic [3:0] k_q;
  logic [1:0] ds_q;
  logic div_start, div_done, div_clip;
  logic signed [minv_pkg::QuoW-1:0] div_quo;
  logic [1:0] rr, cc;
  logic [3:0] ci;

  function automatic logic signed [minv_pkg::MinorW-1:0] minor_f(
      minv_pkg::elem_t [minv_pkg::NumPos-1:0] m, logic [1:0] r, logic [1:0] c);
    logic [1:0] a, b, p, q;
    logic signed [minv_pkg::MinorW-1:0] v;
    a = (r == 2'd0) ? 2'd1 : 2'd0;
    b = (r == 2'd2) ? 2'd1 : 2'd2;
    p = (c == 2'd0) ? 2'd1 : 2'd0;
    q = (c == 2'd2) ? 2'd1 : 2'd2;
    v = minv_pkg::MinorW'(m[a*3+p] * m[b*3+q]) - minv_pkg::MinorW'(m[a*3+q] * m[b*3+p]);
    if (r[0] ^ c[0]) v = -v;
    return v;
  endfunction

  // entry k of the inverse uses cofactor (col,row)
  assign rr = (k_q < 4'd3) ? 2'd0 : (k_q < 4'd6) ? 2'd1 : 2'd2;
  assign cc = 2'(k_q - 4'(rr) * 4'd3);
  assign ci = 4'(cc) * 4'd3 + 4'(rr);

  assign job_ready_o = (st_q == minv_pkg::S_IDLE);
  assign div_start = (st_q == minv_pkg::S_DIV) && (ds_q == 2'd0) && (det_q != '0);

  minv_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(cof_q[ci]), .den_i(det_q),
    .done_o(div_done), .quo_o(div_quo), .clip_o(div_clip)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      minv_pkg::S_IDLE:  if (job_valid_i) st_d = minv_pkg::S_MINOR;
      minv_pkg::S_MINOR: if (k_q == 4'd8) st_d = minv_pkg::S_DET;
      minv_pkg::S_DET:   if (k_q == 4'd3) st_d = minv_pkg::S_DIV;
      minv_pkg::S_DIV:   if (det_q == '0 || div_done) st_d = minv_pkg::S_OUT;
      minv_pkg::S_OUT:   if (out_ch.ready)
                           st_d = (k_q == 4'd8) ? minv_pkg::S_IDLE : minv_pkg::S_DIV;
      default:           st_d = minv_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= minv_pkg::S_IDLE;
      k_q  <= '0;
      ds_q <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        minv_pkg::S_IDLE:  k_q <= '0;
        minv_pkg::S_MINOR: k_q <= (k_q == 4'd8) ? 4'd0 : k_q + 4'd1;
        minv_pkg::S_DET:   k_q <= (k_q == 4'd3) ? 4'd0 : k_q + 4'd1;
        minv_pkg::S_DIV: begin
          ds_q <= 2'd1;
          if (st_d == minv_pkg::S_OUT) out_ch.valid <= 1'b1;
        end
        minv_pkg::S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          ds_q <= 2'd0;
          k_q  <= k_q + 4'd1;
        end
        default: k_q <= '0;
      endcase
    end
  end

  // datapath: one minor per cycle (row rr, column cc of k), then det over three products
  always_ff @(posedge clk_i) begin
    case (st_q)
      minv_pkg::S_IDLE: if (job_valid_i) m_q <= job_i.mat;
      minv_pkg::S_MINOR: cof_q[k_q] <= minor_f(m_q, rr, cc);
      minv_pkg::S_DET: begin
        if (k_q == 4'd0) det_q <= '0;
        else det_q <= det_q + prod_q;
        if (k_q < 4'd3)
          prod_q <= minv_pkg::DetW'(m_q[k_q] * cof_q[k_q]);
      end
      minv_pkg::S_DIV: if (st_d == minv_pkg::S_OUT) begin
        out_ch.out_position  <= k_q;
        out_ch.inverse_value <= (det_q == '0) ? '0 : div_quo;
        out_ch.clipped       <= (det_q == '0) ? 1'b0 : div_clip;
        out_ch.determinant   <= det_q;
        out_ch.singular      <= (det_q == '0);
        out_ch.last_entry    <= (k_q == 4'd8);
      end
      default: ;
    endcase
  end
endmodule

// ----- rtl/core/matrix_inverse_3x3.sv -----
// A taken start request waits in the job queue until the back end is idle, which then computes
// the minors, the determinant and each entry by serial division (none for a singular matrix),
// each further entry once the previous one is taken; the divider stops early on saturation.
// Loads are taken every cycle until two start requests wait in the two-deep job queue.
// Reset (rst_ni low, asynchronous) clears the stored matrix to zero and idles both halves.
// Each request with start_req set yields nine results in row-major order.
module matrix_inverse_3x3 (
  input  logic clk_i,
  input  logic rst_ni,
  minv_in_if.sink    in_ch,
  minv_out_if.source out_ch
);
  logic job_valid, job_ready;
  minv_pkg::job_t job;

  minv_front u_front (
    .clk_i, .rst_ni, .in_ch, .job_valid_o(job_valid), .job_o(job), .job_ready_i(job_ready)
  );

  minv_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .job_ready_o(job_ready),
    .out_ch
  );
endmodule

// ----- test/matrix_inverse_3x3_tb.sv -----
// Self-checking testbench for the 3x3 fixed-point matrix inverter.
module matrix_inverse_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumItems  = 150;
  localparam int QuietTail = 30;
  localparam int HoldCyc   = 300;
  localparam int IdleLimit = 20000;
  localparam int TailWait  = 200;

  // How the expected results of a directed row are obtained
  typedef enum logic [1:0] {
    CHK_MODEL, CHK_SINGULAR, CHK_UNIT
  } chk_kind_e;

  typedef struct packed {
    logic [minv_pkg::PosW-1:0]  pos;
    logic [minv_pkg::ElemW-1:0] elem;
    logic                       start;
    chk_kind_e                  kind;
  } load_row_t;

  typedef struct packed {
    logic [minv_pkg::PosW-1:0]        pos;
    logic signed [minv_pkg::QuoW-1:0] val;
    logic signed [minv_pkg::DetW-1:0] det;
    logic                             sing;
    logic                             clip;
    logic                             last;
  } inv_entry_t;

  logic clk_i;
  logic rst_ni;

  minv_in_if  in_ch();
  minv_out_if out_ch();

  matrix_inverse_3x3 u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the stored matrix and the pending inverse entries
  minv_pkg::elem_t shadow_mat [minv_pkg::NumPos];
  inv_entry_t inv_expect_q [$];
  int         fail_cnt;
  int         loads_sent;
  bit         quiet;
  bit         hold_req;

  // Directed loads: empty matrix, identity, out-of-range index, extremes, clipping
  localparam int NumDir = 21;
  load_row_t dir_rows [NumDir] = '{
    '{4'd0, 16'sd0,      1'b1, CHK_SINGULAR},  // cleared store is singular
    '{4'd0, 16'sd256,    1'b0, CHK_MODEL},
    '{4'd4, 16'sd256,    1'b0, CHK_MODEL},
    '{4'd8, 16'sd256,    1'b1, CHK_UNIT},      // identity
    '{4'd15, 16'h7fff,   1'b1, CHK_UNIT},      // out of range: store untouched
    '{4'd9, 16'h8000,    1'b0, CHK_MODEL},
    '{4'd1, 16'sd32767,  1'b0, CHK_MODEL},
    '{4'd0, 16'sd1,      1'b0, CHK_MODEL},
    '{4'd4, 16'sd1,      1'b0, CHK_MODEL},
    '{4'd8, 16'sd1,      1'b1, CHK_MODEL},     // tiny det, huge cofactor: clips
    '{4'd0, 16'h8000,    1'b0, CHK_MODEL},
    '{4'd2, 16'h8000,    1'b0, CHK_MODEL},
    '{4'd3, 16'sd32767,  1'b0, CHK_MODEL},
    '{4'd5, 16'h8000,    1'b0, CHK_MODEL},
    '{4'd6, 16'sd32767,  1'b0, CHK_MODEL},
    '{4'd7, 16'h8000,    1'b1, CHK_MODEL},
    '{4'd1, 16'hffff,    1'b1, CHK_MODEL},
    '{4'd0, 16'sd0,      1'b0, CHK_MODEL},
    '{4'd3, 16'sd0,      1'b0, CHK_MODEL},
    '{4'd6, 16'sd0,      1'b1, CHK_SINGULAR},  // zero column
    '{4'd12, 16'sd77,    1'b0, CHK_MODEL}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Signed 2x2 minor with row r and column c removed
  function automatic longint minor2(int r, int c);
    int a, b, p, q;
    a = (r == 0) ? 1 : 0;
    b = (r == 2) ? 1 : 2;
    p = (c == 0) ? 1 : 0;
    q = (c == 2) ? 1 : 2;
    return longint'(shadow_mat[a*3+p]) * longint'(shadow_mat[b*3+q])
         - longint'(shadow_mat[a*3+q]) * longint'(shadow_mat[b*3+p]);
  endfunction

  // num * 2^24 / den, truncated toward zero, saturated to 32 bits
  function automatic logic [minv_pkg::QuoW:0] fixed_quotient(longint num, longint den);
    logic neg, clip;
    longint unsigned n, d, lim, q, r;
    longint res;
    neg  = (num < 0) != (den < 0);
    n    = (num < 0) ? -num : num;
    d    = (den < 0) ? -den : den;
    lim  = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    q    = n / d;
    r    = n % d;
    clip = (q > lim);
    for (int k = 0; k < minv_pkg::ShiftW && !clip; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
      if (q > lim) clip = 1'b1;
    end
    if (clip) q = lim;
    res = neg ? -longint'(q) : longint'(q);
    return {clip, res[minv_pkg::QuoW-1:0]};
  endfunction

  // Queue the nine inverse entries of the shadow matrix
  task automatic predict_inverse(chk_kind_e kind);
    longint det;
    longint cof;
    logic [minv_pkg::QuoW:0] qr;
    inv_entry_t e;
    det = longint'(shadow_mat[0]) * minor2(0, 0) - longint'(shadow_mat[1]) * minor2(0, 1)
        + longint'(shadow_mat[2]) * minor2(0, 2);
    for (int k = 0; k < minv_pkg::NumPos; k++) begin
      e.pos  = minv_pkg::PosW'(k);
      e.det  = det[minv_pkg::DetW-1:0];
      e.sing = (det == 0);
      e.clip = 1'b0;
      e.val  = '0;
      e.last = (k == minv_pkg::NumPos - 1);
      if (det != 0) begin
        cof = minor2(k % 3, k / 3);
        if (((k / 3) + (k % 3)) % 2 == 1) cof = -cof;
        qr     = fixed_quotient(cof, det);
        e.val  = qr[minv_pkg::QuoW-1:0];
        e.clip = qr[minv_pkg::QuoW];
      end
      // rows whose answer is known by inspection
      if (kind == CHK_SINGULAR) begin
        e.val = '0; e.det = '0; e.sing = 1'b1; e.clip = 1'b0;
      end else if (kind == CHK_UNIT) begin
        e.val = (k % 4 == 0) ? 32'sd65536 : 32'sd0;
        e.det = 49'sd16777216; e.sing = 1'b0; e.clip = 1'b0;
      end
      inv_expect_q.push_back(e);
    end
  endtask

  // Offer one load request; optional idle burst before it
  task automatic send_load(logic [minv_pkg::PosW-1:0] pos, logic [minv_pkg::ElemW-1:0] elem,
                           logic start, chk_kind_e kind);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    in_ch.valid     = 1'b1;
    in_ch.position  = pos;
    in_ch.element   = elem;
    in_ch.start_req = start;
    do @(posedge clk_i); while (!in_ch.ready);
    if (pos < minv_pkg::NumPos) shadow_mat[pos] = elem;
    if (start) predict_inverse(kind);
    loads_sent++;
  endtask

  // Hold the sender off until every pending entry has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (inv_expect_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [minv_pkg::ElemW-1:0] rand_elem();
    case ($urandom_range(0, 3))
      0: return minv_pkg::ElemW'($urandom());
      1: return minv_pkg::ElemW'(int'($urandom_range(0, 1024)) - 512);
      2: return minv_pkg::ElemW'(int'($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'sd256;
          3: return -16'sd256;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [minv_pkg::ElemW-1:0] vals [minv_pkg::NumPos];
    int order [minv_pkg::NumPos];
    int n, j, tmp;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.position  = '0;
    in_ch.element   = '0;
    in_ch.start_req = 1'b0;
    fail_cnt        = 0;
    loads_sent      = 0;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    foreach (shadow_mat[i]) shadow_mat[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_load(dir_rows[i].pos, dir_rows[i].elem, dir_rows[i].start, dir_rows[i].kind);
    drain_results();

    while (loads_sent < NumItems) begin
      quiet = (loads_sent >= NumItems - QuietTail);
      if (loads_sent >= 60 && loads_sent < 62) hold_req = 1'b1;
      if (loads_sent >= 100 && loads_sent < 103) drain_results();
      if ($urandom_range(0, 4) != 0) begin
        // well-formed: fill a full or partial matrix, then start
        foreach (vals[i]) vals[i] = rand_elem();
        if ($urandom_range(0, 7) == 0)
          for (int i = 6; i < 9; i++) vals[i] = vals[i-3];
        foreach (order[i]) order[i] = i;
        for (int i = minv_pkg::NumPos - 1; i > 0; i--) begin
          j = int'($urandom_range(0, i));
          tmp = order[i]; order[i] = order[j]; order[j] = tmp;
        end
        n = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) : minv_pkg::NumPos;
        for (int i = 0; i < n; i++)
          send_load(minv_pkg::PosW'(order[i]), vals[order[i]], i == n - 1, CHK_MODEL);
      end else begin
        // noise: any index, occasional start
        send_load(minv_pkg::PosW'($urandom_range(0, 15)), minv_pkg::ElemW'($urandom()),
                  $urandom_range(0, 3) == 0, CHK_MODEL);
      end
    end
    @(negedge clk_i);
    in_ch.valid = 1'b0;

    while (inv_expect_q.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    if (inv_expect_q.size() != 0 || fail_cnt != 0) begin
      $display("** matrix_inverse_3x3: FAILED **");
    end else begin
      $display("** matrix_inverse_3x3: PASSED **");
    end
    $finish;
  end

  // Result side ready: random stall bursts plus one long hold-off
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HoldCyc) @(negedge clk_i);
        hold_req = 1'b0;
        out_ch.ready = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 15);
        out_ch.ready = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Compare each accepted inverse entry with the oldest prediction
  always @(posedge clk_i) begin
    inv_entry_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (inv_expect_q.size() == 0) begin
        $error("unexpected result at position %0d", out_ch.out_position);
        fail_cnt++;
      end else begin
        e = inv_expect_q.pop_front();
        if (out_ch.out_position !== e.pos) begin
          $error("out_position exp %0d got %0d", e.pos, out_ch.out_position); fail_cnt++;
        end
        if (out_ch.inverse_value !== e.val) begin
          $error("inverse_value exp %0d got %0d", e.val, out_ch.inverse_value); fail_cnt++;
        end
        if (out_ch.determinant !== e.det) begin
          $error("determinant exp %0d got %0d", e.det, out_ch.determinant); fail_cnt++;
        end
        if (out_ch.singular !== e.sing) begin
          $error("singular exp %0d got %0d", e.sing, out_ch.singular); fail_cnt++;
        end
        if (out_ch.clipped !== e.clip) begin
          $error("clipped exp %0d got %0d", e.clip, out_ch.clipped); fail_cnt++;
        end
        if (out_ch.last_entry !== e.last) begin
          $error("last_entry exp %0d got %0d", e.last, out_ch.last_entry); fail_cnt++;
        end
      end
    end
  end

  // Watchdog: cycles with no request moving on either side
  initial begin
    int idle_cyc;
    idle_cyc = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cyc = 0;
      else
        idle_cyc++;
      if (idle_cyc >= IdleLimit) begin
        $display("** matrix_inverse_3x3: FAILED **");
        $finish;
      end
    end
  end

endmodule
